### hdl/dbcs_pkg.sv
// Shared types and constants for the dual battery charge selector.
// No dependencies; used by dbcs_cfg, dbcs_decide and the top level.
package dbcs_pkg;

	localparam int MV_W    = 16;
	localparam int TICK_W  = 8;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UNDER_VOLTAGE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHARGE_MIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_VOLTAGE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_MARGIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MANUAL_MARGIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_DELAY     = 3'd5;

	// selection modes
	localparam logic [1:0] MODE_AUTO  = 2'd0;
	localparam logic [1:0] MODE_ONLY1 = 2'd1;

	// latched battery choice
	localparam logic [1:0] CHOICE_NONE = 2'd0;
	localparam logic [1:0] CHOICE_ONE  = 2'd1;
	localparam logic [1:0] CHOICE_TWO  = 2'd2;

	typedef enum logic [2:0] {
		ST_SEARCH = 3'd0,
		ST_CHG1   = 3'd1,
		ST_CHG2   = 3'd2,
		ST_DIS1   = 3'd3,
		ST_DIS2   = 3'd4
	} ctl_state_t;

	typedef struct packed {
		logic [MV_W-1:0]   under_voltage_mv;
		logic [MV_W-1:0]   charge_min_mv;
		logic [MV_W-1:0]   full_voltage_mv;
		logic [MV_W-1:0]   auto_full_margin_mv;
		logic [MV_W-1:0]   manual_full_margin_mv;
		logic [TICK_W-1:0] full_delay_ticks;
	} cfg_t;

	typedef struct packed {
		ctl_state_t        mode_state;
		ctl_state_t        last_cmd;
		logic [1:0]        chg_choice;
		logic [1:0]        dis_choice;
		logic [TICK_W-1:0] full_cnt;
	} ctl_t;

	typedef struct packed {
		logic [MV_W-1:0] battery_one_mv;
		logic [MV_W-1:0] battery_two_mv;
		logic [MV_W-1:0] adapter_mv;
		logic [1:0]      select_mode;
	} sample_t;

endpackage

### hdl/dbcs_cfg.sv
// Configuration register file for the charge selector.
// Depends on dbcs_pkg for the register indexes and cfg_t.
module dbcs_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dbcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dbcs_pkg::MV_W-1:0]        cfg_data,
	output dbcs_pkg::cfg_t                   cfg
);

	dbcs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.under_voltage_mv      <= 16'd6000;
			cfg_q.charge_min_mv         <= 16'd13100;
			cfg_q.full_voltage_mv       <= 16'd16800;
			cfg_q.auto_full_margin_mv   <= 16'd100;
			cfg_q.manual_full_margin_mv <= 16'd10;
			cfg_q.full_delay_ticks      <= 8'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				dbcs_pkg::REG_UNDER_VOLTAGE: cfg_q.under_voltage_mv <= cfg_data;
				dbcs_pkg::REG_CHARGE_MIN:    cfg_q.charge_min_mv <= cfg_data;
				dbcs_pkg::REG_FULL_VOLTAGE:  cfg_q.full_voltage_mv <= cfg_data;
				dbcs_pkg::REG_AUTO_MARGIN:   cfg_q.auto_full_margin_mv <= cfg_data;
				dbcs_pkg::REG_MANUAL_MARGIN: cfg_q.manual_full_margin_mv <= cfg_data;
				dbcs_pkg::REG_FULL_DELAY:
					cfg_q.full_delay_ticks <= cfg_data[dbcs_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/dbcs_decide.sv
// Next-state and command logic for one sample of the charge selector.
// Depends on dbcs_pkg for cfg_t, ctl_t, sample_t and the state codes.
module dbcs_decide (
	input  dbcs_pkg::cfg_t    cfg,
	input  dbcs_pkg::sample_t smp,
	input  dbcs_pkg::ctl_t    cur,
	output dbcs_pkg::ctl_t    nxt,
	output logic              apply_command
);

	logic               adapter, b1_low, b2_low;
	logic signed [16:0] head1, head2, am, mm;
	logic               one_sel;
	logic [15:0]        v_sel;
	logic               v_low;
	logic signed [16:0] head_v;

	assign adapter = smp.adapter_mv >= cfg.under_voltage_mv;
	assign b1_low  = smp.battery_one_mv < cfg.under_voltage_mv;
	assign b2_low  = smp.battery_two_mv < cfg.under_voltage_mv;
	// headroom below full voltage, signed
	assign head1 = $signed({1'b0, cfg.full_voltage_mv}) - $signed({1'b0, smp.battery_one_mv});
	assign head2 = $signed({1'b0, cfg.full_voltage_mv}) - $signed({1'b0, smp.battery_two_mv});
	assign am    = $signed({1'b0, cfg.auto_full_margin_mv});
	assign mm    = $signed({1'b0, cfg.manual_full_margin_mv});
	assign one_sel = smp.select_mode == dbcs_pkg::MODE_ONLY1;
	assign v_sel   = one_sel ? smp.battery_one_mv : smp.battery_two_mv;
	assign v_low   = one_sel ? b1_low : b2_low;
	assign head_v  = one_sel ? head1 : head2;

	always_comb begin
		logic b1_lower, b2_lower, b1_ok, b2_ok, full_hit;
		logic [dbcs_pkg::TICK_W-1:0] cnt_inc;
		nxt      = cur;
		b1_lower = (smp.battery_one_mv < smp.battery_two_mv) || b2_low;
		b1_ok    = smp.battery_one_mv > cfg.charge_min_mv;
		b2_ok    = smp.battery_two_mv > cfg.charge_min_mv;
		b2_lower = 1'b0;
		full_hit = 1'b0;
		cnt_inc  = cur.full_cnt + 8'd1;
		if (smp.select_mode == dbcs_pkg::MODE_AUTO) begin
			if (adapter) begin
				nxt.dis_choice = dbcs_pkg::CHOICE_NONE;
				b2_lower = (smp.battery_one_mv > smp.battery_two_mv) || b1_low;
				if (cur.chg_choice == dbcs_pkg::CHOICE_NONE) begin
					if (b1_lower && b1_ok && head1 > am) begin
						nxt.chg_choice = dbcs_pkg::CHOICE_ONE;
						nxt.mode_state = dbcs_pkg::ST_CHG1;
					end else if (b2_lower && b2_ok && head2 > am) begin
						nxt.chg_choice = dbcs_pkg::CHOICE_TWO;
						nxt.mode_state = dbcs_pkg::ST_CHG2;
					end else begin
						nxt.mode_state = dbcs_pkg::ST_SEARCH;
					end
				end
				// count ticks where the latched battery reads full or absent
				full_hit = ((b1_low || head1 < am) && nxt.chg_choice == dbcs_pkg::CHOICE_ONE)
					|| ((b2_low || head2 < am) && nxt.chg_choice == dbcs_pkg::CHOICE_TWO);
				if (full_hit) begin
					if (cnt_inc == cfg.full_delay_ticks) begin
						nxt.full_cnt   = '0;
						nxt.mode_state = dbcs_pkg::ST_SEARCH;
						nxt.chg_choice = dbcs_pkg::CHOICE_NONE;
					end else begin
						nxt.full_cnt = cnt_inc;
					end
				end
			end else begin
				nxt.chg_choice = dbcs_pkg::CHOICE_NONE;
				b2_lower = (smp.battery_two_mv < smp.battery_one_mv) || b1_low;
				if (cur.dis_choice == dbcs_pkg::CHOICE_NONE) begin
					if (b1_lower && b1_ok) begin
						nxt.dis_choice = dbcs_pkg::CHOICE_ONE;
						nxt.mode_state = dbcs_pkg::ST_DIS1;
					end else if (b2_lower && b2_ok) begin
						nxt.dis_choice = dbcs_pkg::CHOICE_TWO;
						nxt.mode_state = dbcs_pkg::ST_DIS2;
					end else begin
						nxt.mode_state = dbcs_pkg::ST_SEARCH;
					end
				end
				// release the discharge battery once it drops out
				if ((nxt.dis_choice == dbcs_pkg::CHOICE_ONE && b1_low)
					|| (nxt.dis_choice == dbcs_pkg::CHOICE_TWO && b2_low))
					nxt.dis_choice = dbcs_pkg::CHOICE_NONE;
			end
		end else begin
			nxt.chg_choice = dbcs_pkg::CHOICE_NONE;
			nxt.dis_choice = dbcs_pkg::CHOICE_NONE;
			if (adapter) begin
				if (v_sel > cfg.charge_min_mv && v_sel < cfg.full_voltage_mv)
					nxt.mode_state = one_sel ? dbcs_pkg::ST_CHG1 : dbcs_pkg::ST_CHG2;
				else if (v_low || head_v < mm)
					nxt.mode_state = dbcs_pkg::ST_SEARCH;
			end else begin
				nxt.mode_state = one_sel ? dbcs_pkg::ST_DIS1 : dbcs_pkg::ST_DIS2;
			end
		end
		apply_command = cur.last_cmd != nxt.mode_state;
		nxt.last_cmd  = nxt.mode_state;
	end

endmodule

### hdl/dual_battery_charge_selector_top.sv
// Top level of the dual battery charge selector: input stage, decision, result register.
// Depends on dbcs_pkg, dbcs_cfg and dbcs_decide.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: b1 mV, b2 mV, adapter mV; tuser: mode
//  m_*     | out | m_tvalid/m_tready  | tdata: controller_state, apply_command
//  cfg_*   | in  | cfg_we             | cfg_index selects register, cfg_data value
//
// A beat in the input stage moves into the result register once that register is free
// or being read, and its result is then offered; one beat per cycle is sustained while
// m_tready stays high. The controller state is updated in the same edge that loads the
// result register, so the next sample already sees it. A stalled result holds
// in the output register; the input stage fills behind it, then s_tready drops.
// Reset clears the state to adapter search, both choices to none, the tick
// count to zero and the registers to their default thresholds.
module dual_battery_charge_selector_top (
	input  logic        clk,
	input  logic        arst_n,
	// sample beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // [15:0] battery_one_mv, [31:16] battery_two_mv,
	                              // [47:32] adapter_mv
	input  logic [1:0]  s_tuser,  // [1:0] select_mode
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [2:0] controller_state, [3] apply_command, rest zero
	// configuration writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	dbcs_pkg::cfg_t    cfg;
	dbcs_pkg::sample_t smp_s1;
	logic              vld_s1;
	dbcs_pkg::ctl_t    ctl_q, ctl_nxt;
	logic              apply_nxt;
	logic              out_vld_q;
	logic [2:0]        out_state_q;
	logic              out_apply_q;
	logic              advance;

	dbcs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dbcs_decide u_decide (
		.cfg           (cfg),
		.smp           (smp_s1),
		.cur           (ctl_q),
		.nxt           (ctl_nxt),
		.apply_command (apply_nxt)
	);

	// move the staged sample into the result register when that register frees up
	assign advance  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;

	// input stage: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	// input stage: payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			smp_s1.battery_one_mv <= s_tdata[15:0];
			smp_s1.battery_two_mv <= s_tdata[31:16];
			smp_s1.adapter_mv     <= s_tdata[47:32];
			smp_s1.select_mode    <= s_tuser;
		end
	end

	// controller state advances once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.mode_state <= dbcs_pkg::ST_SEARCH;
			ctl_q.last_cmd   <= dbcs_pkg::ST_SEARCH;
			ctl_q.chg_choice <= dbcs_pkg::CHOICE_NONE;
			ctl_q.dis_choice <= dbcs_pkg::CHOICE_NONE;
			ctl_q.full_cnt   <= '0;
		end else if (advance) begin
			ctl_q <= ctl_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_state_q <= ctl_nxt.mode_state;
			out_apply_q <= apply_nxt;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0000, out_apply_q, out_state_q};

	// a held result always matches the last commanded state
	a_result_is_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> out_state_q == ctl_q.last_cmd)
		else $error("result state differs from last commanded state");

	// charge and discharge choices are never latched together
	a_choice_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl_q.chg_choice != dbcs_pkg::CHOICE_NONE
			&& ctl_q.dis_choice != dbcs_pkg::CHOICE_NONE))
		else $error("charge and discharge choices both set");

	// back-pressure only when both stages are full
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (vld_s1 && out_vld_q && !m_tready))
		else $error("input stalled with room in the pipeline");

	// a command strobe means the state moved on this beat
	a_apply_change: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (out_apply_q == (out_state_q != $past(ctl_q.last_cmd))))
		else $error("command strobe does not match state change");

endmodule

### bench/dual_battery_charge_selector_top_tb.sv
// Self-checking bench for dual_battery_charge_selector_top: streams voltage samples in,
// predicts the controller state and command strobe per beat, compares every result beat.
// Depends on dbcs_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module dual_battery_charge_selector_top_tb;

	// manual modes the package leaves unnamed
	localparam logic [1:0] MODE_ONLY2 = 2'd2;
	localparam logic [1:0] MODE_THREE = 2'd3;

	typedef struct {
		dbcs_pkg::ctl_state_t state;
		logic                 apply;
	} state_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	dual_battery_charge_selector_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Mirror of the thresholds and of the controller state.
	dbcs_pkg::cfg_t        thr;
	dbcs_pkg::ctl_state_t  sel_state;
	dbcs_pkg::ctl_state_t  sel_last_cmd;
	logic [1:0]            sel_chg;
	logic [1:0]            sel_dis;
	logic [7:0]            sel_full_cnt;

	dbcs_pkg::sample_t sample_q[$];        // samples waiting to be offered
	state_report_t     state_reports_q[$]; // predicted result beats, oldest first
	dbcs_pkg::sample_t on_bus;             // sample currently presented on s_*

	int  fail_count = 0;
	bit  calm = 1'b0;                  // no idling on either side when set
	int  holdoffs_asked = 0;
	int  holdoffs_done = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	int  holdoff_left = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// Hard stop in case the handshake locks up.
	initial begin
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// Signed distance from full; negative once a battery reads above full.
	function automatic int room_below_full(logic [15:0] v);
		int f;
		int x;
		f = thr.full_voltage_mv;
		x = v;
		return f - x;
	endfunction

	// Count one full/absent tick; end the charge once the delay is reached.
	// The count is 8 bits and wraps, so a zero delay takes 256 ticks.
	function automatic void count_full_tick();
		sel_full_cnt = sel_full_cnt + 8'd1;
		if (sel_full_cnt == thr.full_delay_ticks) begin
			sel_state = dbcs_pkg::ST_SEARCH;
			sel_full_cnt = '0;
			sel_chg = dbcs_pkg::CHOICE_NONE;
		end
	endfunction

	// Advance the mirrored controller by one sample and queue the result beat.
	function automatic void select_battery(dbcs_pkg::sample_t smp);
		int          am;
		int          mm;
		logic        adapter;
		logic        b1_low;
		logic        b2_low;
		logic        one;
		logic [15:0] b1;
		logic [15:0] b2;
		logic [15:0] v;
		logic        v_low;
		logic        apply;
		b1 = smp.battery_one_mv;
		b2 = smp.battery_two_mv;
		am = thr.auto_full_margin_mv;
		mm = thr.manual_full_margin_mv;
		adapter = smp.adapter_mv >= thr.under_voltage_mv;
		b1_low = b1 < thr.under_voltage_mv;
		b2_low = b2 < thr.under_voltage_mv;
		if (smp.select_mode == dbcs_pkg::MODE_AUTO) begin
			if (adapter) begin
				sel_dis = dbcs_pkg::CHOICE_NONE;
				if (sel_chg == dbcs_pkg::CHOICE_NONE) begin
					if ((b1 < b2 || b2_low) && b1 > thr.charge_min_mv &&
					    room_below_full(b1) > am) begin
						sel_chg = dbcs_pkg::CHOICE_ONE;
						sel_state = dbcs_pkg::ST_CHG1;
					end else if ((b1 > b2 || b1_low) && b2 > thr.charge_min_mv &&
					             room_below_full(b2) > am) begin
						sel_chg = dbcs_pkg::CHOICE_TWO;
						sel_state = dbcs_pkg::ST_CHG2;
					end else begin
						sel_state = dbcs_pkg::ST_SEARCH;
					end
				end
				if ((b1_low || room_below_full(b1) < am) && sel_chg == dbcs_pkg::CHOICE_ONE)
					count_full_tick();
				else if ((b2_low || room_below_full(b2) < am)
				         && sel_chg == dbcs_pkg::CHOICE_TWO)
					count_full_tick();
			end else begin
				sel_chg = dbcs_pkg::CHOICE_NONE;
				if (sel_dis == dbcs_pkg::CHOICE_NONE) begin
					if ((b1 < b2 || b2_low) && b1 > thr.charge_min_mv) begin
						sel_dis = dbcs_pkg::CHOICE_ONE;
						sel_state = dbcs_pkg::ST_DIS1;
					end else if ((b2 < b1 || b1_low) && b2 > thr.charge_min_mv) begin
						sel_dis = dbcs_pkg::CHOICE_TWO;
						sel_state = dbcs_pkg::ST_DIS2;
					end else begin
						sel_state = dbcs_pkg::ST_SEARCH;
					end
				end
				if (sel_dis == dbcs_pkg::CHOICE_ONE && b1_low)
					sel_dis = dbcs_pkg::CHOICE_NONE;
				else if (sel_dis == dbcs_pkg::CHOICE_TWO && b2_low)
					sel_dis = dbcs_pkg::CHOICE_NONE;
			end
		end else begin
			// mode three behaves as battery two only
			one = (smp.select_mode == dbcs_pkg::MODE_ONLY1);
			v = one ? b1 : b2;
			v_low = one ? b1_low : b2_low;
			sel_dis = dbcs_pkg::CHOICE_NONE;
			sel_chg = dbcs_pkg::CHOICE_NONE;
			if (adapter) begin
				if (v > thr.charge_min_mv && v < thr.full_voltage_mv)
					sel_state = one ? dbcs_pkg::ST_CHG1 : dbcs_pkg::ST_CHG2;
				else if (v_low || room_below_full(v) < mm)
					sel_state = dbcs_pkg::ST_SEARCH;
				// otherwise hold the state as it is
			end else begin
				sel_state = one ? dbcs_pkg::ST_DIS1 : dbcs_pkg::ST_DIS2;
			end
		end
		apply = 1'b0;
		if (sel_last_cmd != sel_state) begin
			apply = 1'b1;
			sel_last_cmd = sel_state;
		end
		state_reports_q.push_back('{sel_state, apply});
	endfunction

	// ---------------------------------------------------------------------
	// Sender: offer queued samples, with random bursts of idle cycles.
	// s_tvalid gets at most one nonblocking write per edge.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			// predict on the edge the beat is taken
			if (s_tvalid)
				select_battery(on_bus);
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (sample_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(0, 5);
				s_tvalid <= 1'b0;
			end else begin
				on_bus = sample_q.pop_front();
				s_tdata <= {on_bus.adapter_mv, on_bus.battery_two_mv, on_bus.battery_one_mv};
				s_tuser <= on_bus.select_mode;
				s_tvalid <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: random stall bursts, plus long hold-offs on request so the
	// block fills up and drops s_tready while beats keep being offered.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (holdoff_left > 0) begin
			holdoff_left--;
			m_tready <= 1'b0;
		end else if (holdoffs_done != holdoffs_asked) begin
			holdoffs_done++;
			holdoff_left = 60;
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			recv_gap = $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: compare each result beat with the oldest prediction.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		state_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (state_reports_q.size() == 0) begin
				$display("%0t: result beat with nothing predicted, got state %0d apply %0b",
				         $time, m_tdata[2:0], m_tdata[3]);
				fail_count++;
			end else begin
				want = state_reports_q.pop_front();
				if (m_tdata[2:0] !== want.state) begin
					$display("%0t: controller_state mismatch, expected %0d, actual %0d",
					         $time, want.state, m_tdata[2:0]);
					fail_count++;
				end
				if (m_tdata[3] !== want.apply) begin
					$display("%0t: apply_command mismatch, expected %0b, actual %0b",
					         $time, want.apply, m_tdata[3]);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	task automatic queue_sample(logic [15:0] b1, logic [15:0] b2, logic [15:0] ad,
	                            logic [1:0] mode);
		dbcs_pkg::sample_t smp;
		smp.battery_one_mv = b1;
		smp.battery_two_mv = b2;
		smp.adapter_mv = ad;
		smp.select_mode = mode;
		sample_q.push_back(smp);
	endtask

	// Voltage biased toward the current thresholds, with some pure noise.
	function automatic logic [15:0] pick_mv();
		logic [15:0] jit;
		jit = 16'($urandom_range(0, 6)) - 16'd3;
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 65535));
			1: return thr.under_voltage_mv + jit;
			2: return thr.charge_min_mv + jit;
			3: return thr.full_voltage_mv - thr.auto_full_margin_mv + jit;
			4: return thr.full_voltage_mv - thr.manual_full_margin_mv + jit;
			5: return thr.full_voltage_mv + jit;
			6, 7: return 16'($urandom_range(13000, 16800));
			8: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(0, 6000));
		endcase
	endfunction

	// One run of samples: mostly a fixed mode with slowly drifting batteries
	// and an adapter that comes and goes; now and then pure noise.
	task automatic tell_story(int len);
		logic [15:0] b1;
		logic [15:0] b2;
		logic [15:0] ad;
		logic [1:0]  mode;
		logic        ad_on;
		logic        noisy;
		int          r;
		r = $urandom_range(0, 19);
		mode = (r < 12) ? dbcs_pkg::MODE_AUTO : (r < 15) ? dbcs_pkg::MODE_ONLY1 :
		       (r < 18) ? MODE_ONLY2 : MODE_THREE;
		noisy = ($urandom_range(0, 9) == 0);
		ad_on = ($urandom_range(0, 2) != 0);
		b1 = pick_mv();
		b2 = pick_mv();
		for (int k = 0; k < len; k++) begin
			if (noisy) begin
				queue_sample(16'($urandom), 16'($urandom), 16'($urandom),
				             2'($urandom_range(0, 3)));
			end else begin
				if ($urandom_range(0, 11) == 0)
					ad_on = ~ad_on;
				b1 = ($urandom_range(0, 3) == 0) ? pick_mv() : b1 + 16'($urandom_range(0, 40)) - 16'd20;
				b2 = ($urandom_range(0, 3) == 0) ? pick_mv() : b2 + 16'($urandom_range(0, 40)) - 16'd20;
				if (ad_on)
					ad = ($urandom_range(0, 3) == 0) ? pick_mv()
					     : 16'($urandom_range(thr.under_voltage_mv, 65535));
				else
					ad = 16'($urandom_range(0, thr.under_voltage_mv));
				queue_sample(b1, b2, ad, mode);
			end
		end
	endtask

	task automatic random_phase(int n);
		int sent;
		int len;
		sent = 0;
		while (sent < n) begin
			len = $urandom_range(4, 30);
			tell_story(len);
			sent += len;
		end
	endtask

	// Hold until every sample is taken and every result has come back,
	// then allow the pipeline depth plus slack.
	task automatic wait_drained();
		while (sample_q.size() != 0 || s_tvalid || state_reports_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			dbcs_pkg::REG_UNDER_VOLTAGE: thr.under_voltage_mv = val;
			dbcs_pkg::REG_CHARGE_MIN:    thr.charge_min_mv = val;
			dbcs_pkg::REG_FULL_VOLTAGE:  thr.full_voltage_mv = val;
			dbcs_pkg::REG_AUTO_MARGIN:   thr.auto_full_margin_mv = val;
			dbcs_pkg::REG_MANUAL_MARGIN: thr.manual_full_margin_mv = val;
			dbcs_pkg::REG_FULL_DELAY:    thr.full_delay_ticks = val[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_thresholds(logic [15:0] uv, logic [15:0] cmin, logic [15:0] full,
	                              logic [15:0] am, logic [15:0] mm, logic [7:0] dly);
		wait_drained();
		write_reg(dbcs_pkg::REG_UNDER_VOLTAGE, uv);
		write_reg(dbcs_pkg::REG_CHARGE_MIN, cmin);
		write_reg(dbcs_pkg::REG_FULL_VOLTAGE, full);
		write_reg(dbcs_pkg::REG_AUTO_MARGIN, am);
		write_reg(dbcs_pkg::REG_MANUAL_MARGIN, mm);
		write_reg(dbcs_pkg::REG_FULL_DELAY, {8'd0, dly});
	endtask

	// ---------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------
	initial begin
		thr = '{16'd6000, 16'd13100, 16'd16800, 16'd100, 16'd10, 8'd4};
		sel_state = dbcs_pkg::ST_SEARCH;
		sel_last_cmd = dbcs_pkg::ST_SEARCH;
		sel_chg = dbcs_pkg::CHOICE_NONE;
		sel_dis = dbcs_pkg::CHOICE_NONE;
		sel_full_cnt = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset thresholds.
		// auto charge of the lower battery, then four full ticks end it
		queue_sample(16'd14000, 16'd15000, 16'd20000, dbcs_pkg::MODE_AUTO);
		repeat (4) queue_sample(16'd16750, 16'd15000, 16'd20000, dbcs_pkg::MODE_AUTO);
		// adapter exactly at the undervoltage level counts as present
		queue_sample(16'd15000, 16'd14000, 16'd6000, dbcs_pkg::MODE_AUTO);
		// one below: discharge the lower battery, release it when it drops out
		queue_sample(16'd15000, 16'd14000, 16'd5999, dbcs_pkg::MODE_AUTO);
		queue_sample(16'd15000, 16'd5999, 16'd0, dbcs_pkg::MODE_AUTO);
		queue_sample(16'd15000, 16'd5999, 16'd0, dbcs_pkg::MODE_AUTO);
		queue_sample(16'd0, 16'd0, 16'd0, dbcs_pkg::MODE_AUTO);
		queue_sample(16'd0, 16'd0, 16'd0, dbcs_pkg::MODE_AUTO);
		// overvoltage everywhere: nothing to charge
		queue_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, dbcs_pkg::MODE_AUTO);
		// manual battery one: charge, stop at full, then a hold in between
		queue_sample(16'd13101, 16'd0, 16'hFFFF, dbcs_pkg::MODE_ONLY1);
		queue_sample(16'd16800, 16'd0, 16'hFFFF, dbcs_pkg::MODE_ONLY1);
		queue_sample(16'd13500, 16'd0, 16'hFFFF, dbcs_pkg::MODE_ONLY1);
		queue_sample(16'd10000, 16'd0, 16'hFFFF, dbcs_pkg::MODE_ONLY1);
		queue_sample(16'd14000, 16'd0, 16'd0, dbcs_pkg::MODE_ONLY1);
		// manual battery two, and mode three acting as battery two
		queue_sample(16'd0, 16'd16795, 16'hFFFF, MODE_ONLY2);
		queue_sample(16'd0, 16'd16795, 16'd0, MODE_ONLY2);
		queue_sample(16'd0, 16'd14000, 16'hFFFF, MODE_THREE);
		queue_sample(16'd0, 16'd14000, 16'd0, MODE_THREE);
		// equal batteries at the charge minimum are never chosen
		queue_sample(16'd13100, 16'd13100, 16'd20000, dbcs_pkg::MODE_AUTO);
		queue_sample(16'hAAAA, 16'h5555, 16'hAAAA, dbcs_pkg::MODE_AUTO);
		queue_sample(16'h5555, 16'hAAAA, 16'h5555, MODE_THREE);

		// Reset thresholds, with one long hold-off against a full stream.
		wait_drained();
		holdoffs_asked++;
		random_phase(150);

		// Low extremes: everything selectable, shortest delay.
		set_thresholds(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 8'd1);
		random_phase(120);

		// High extremes: nothing present, largest delay value.
		set_thresholds(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 8'd255);
		random_phase(120);

		// Random thresholds around realistic values, short delays.
		set_thresholds(16'($urandom_range(3000, 9000)), 16'($urandom_range(11000, 14000)),
		               16'($urandom_range(15000, 17500)), 16'($urandom_range(0, 300)),
		               16'($urandom_range(0, 50)), 8'($urandom_range(1, 8)));
		holdoffs_asked++;
		random_phase(200);

		// Zero delay: the tick count has to wrap through 256 before the charge ends.
		set_thresholds(16'd6000, 16'd13100, 16'd16800, 16'd100, 16'd10, 8'd0);
		queue_sample(16'd14000, 16'd15000, 16'd20000, dbcs_pkg::MODE_AUTO);
		repeat (260) queue_sample(16'd16790, 16'($urandom_range(0, 65535)), 16'd20000,
		                          dbcs_pkg::MODE_AUTO);
		random_phase(30);

		// Final stretch with no idling on either side.
		set_thresholds(16'($urandom_range(0, 65535)), 16'($urandom_range(12000, 15000)),
		               16'($urandom_range(15000, 65535)), 16'($urandom_range(0, 65535)),
		               16'($urandom_range(0, 65535)), 8'($urandom_range(1, 255)));
		write_reg(dbcs_pkg::REG_FULL_DELAY, 16'($urandom_range(1, 6)));
		calm = 1'b1;
		random_phase(150);

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && state_reports_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
